// ===== hw/rtl/ppi_pkg.sv =====
// Shared types, codes and helpers of the particle pool integrator.
package ppi_pkg;

  localparam int unsigned MaxParticles = 64;
  localparam int unsigned IdxW = $clog2(MaxParticles);
  localparam int unsigned CntW = $clog2(MaxParticles + 1);
  localparam int unsigned DtW = 25;
  localparam logic [15:0] SpeedMax = 16'd40960;

  localparam logic [1:0] OpEmit  = 2'd0;
  localparam logic [1:0] OpTick  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] StReport  = 2'd0;
  localparam logic [1:0] StEmitted = 2'd1;
  localparam logic [1:0] StDropped = 2'd2;
  localparam logic [1:0] StCleared = 2'd3;

  localparam logic [1:0] RegSpeed   = 2'd0;
  localparam logic [1:0] RegDensity = 2'd1;
  localparam logic [1:0] RegAccelX  = 2'd2;
  localparam logic [1:0] RegAccelY  = 2'd3;

  // One slot of the particle store.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] angle;
    logic signed [31:0] torque;
    logic [30:0]        age;
    logic [30:0]        life;
  } ent_t;

  // Saturate a wide signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/particle_pool_integrator.sv =====
// Particle pool with a fixed-point Euler integrator over a slot memory.
//
// Input channel: in_valid_i / in_stall_o carry one item per beat (emit, tick,
// clear). Output channel: out_valid_o / out_stall_i carry result beats, with
// last_o set on the final beat of an item. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must do so only while the
// block is idle, as the block does not enforce it. Emit and clear give one
// beat each. A tick forms the acceleration step in S_ACC1 and S_ACC2, then
// takes each live particle through read, memory latency, two multiply stages
// and write back, and a particle that dies has its slot refilled from the
// last live slot through the single memory read port. One item is processed
// at a time. Each particle gives one report beat with its state before the
// update. Reset empties the pool and loads the register defaults; the slot
// memory is not cleared, since only slots below the live count are read. A
// stalled output beat holds its register; the walk waits for it before
// showing the next report, and no new item is taken until a tick is done.
module particle_pool_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [30:0]        life_i,
  input  logic signed [31:0] torque_i,
  input  logic [20:0]        delta_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] pos_x_res_o,
  output logic signed [31:0] pos_y_res_o,
  output logic signed [31:0] angle_o,
  output logic [30:0]        age_o,
  output logic [30:0]        life_res_o,
  output logic               last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC1, S_ACC2, S_RD, S_LAT, S_MUL1, S_MUL2, S_WB, S_MVLAT, S_MV
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [15:0]        speed_q;
  logic [20:0]        dens_q;
  logic signed [31:0] accx_q, accy_q;

  // Slot memory with registered read data.
  ppi_pkg::ent_t mem_q [ppi_pkg::MaxParticles];
  ppi_pkg::ent_t rdata_q;
  logic                     rd_en, wr_en;
  logic [ppi_pkg::IdxW-1:0] rd_addr, wr_addr;
  ppi_pkg::ent_t            wr_data;

  logic [ppi_pkg::CntW-1:0] live_q;
  logic [ppi_pkg::IdxW-1:0] k_q;
  logic [ppi_pkg::DtW-1:0]  dt_q;
  logic signed [47:0]       ax_q, ay_q;
  logic signed [41:0]       mt_q, mx1_q, my1_q;
  logic signed [47:0]       mx_q, my_q;

  logic out_valid_q;
  logic out_free;
  logic in_acc;
  logic out_load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // A new output beat is loaded for emit, clear and each particle report.
  assign out_load = ((state_q == S_IDLE) && in_acc
                     && ((op_i == ppi_pkg::OpEmit) || (op_i == ppi_pkg::OpClear)))
                    || ((state_q == S_MUL1) && out_free);

  // Scaled time step from the input beat.
  logic [15:0] spd;
  logic [36:0] dt_full;
  assign spd     = (speed_q > ppi_pkg::SpeedMax) ? ppi_pkg::SpeedMax : speed_q;
  assign dt_full = {16'd0, delta_time_i} * {21'd0, spd};

  // First multiply stage: rate times dt, floored to Q16.16.
  logic signed [31:0] m1a, m1b;
  logic signed [57:0] p_t, p_a, p_b;
  logic signed [25:0] dt_s;
  assign dt_s = $signed({1'b0, dt_q});
  assign m1a  = (state_q == S_ACC1) ? accx_q : rdata_q.vel_x;
  assign m1b  = (state_q == S_ACC1) ? accy_q : rdata_q.vel_y;
  assign p_t  = rdata_q.torque * dt_s;
  assign p_a  = m1a * dt_s;
  assign p_b  = m1b * dt_s;

  // Second multiply stage: density scaling, floored.
  logic signed [21:0] dens_s;
  logic signed [63:0] q_a, q_b;
  assign dens_s = $signed({1'b0, dens_q});
  assign q_a    = mx1_q * dens_s;
  assign q_b    = my1_q * dens_s;

  // Write-back values of the current particle.
  ppi_pkg::ent_t upd;
  logic [31:0]   age_sum;
  logic [30:0]   age_new;
  logic          dead;
  always_comb begin
    upd        = rdata_q;
    upd.angle  = ppi_pkg::sat32({{16{rdata_q.angle[31]}}, rdata_q.angle}
                                + {{6{mt_q[41]}}, mt_q});
    upd.pos_x  = ppi_pkg::sat32({{16{rdata_q.pos_x[31]}}, rdata_q.pos_x} + mx_q);
    upd.pos_y  = ppi_pkg::sat32({{16{rdata_q.pos_y[31]}}, rdata_q.pos_y} + my_q);
    upd.vel_x  = ppi_pkg::sat32({{16{rdata_q.vel_x[31]}}, rdata_q.vel_x} + ax_q);
    upd.vel_y  = ppi_pkg::sat32({{16{rdata_q.vel_y[31]}}, rdata_q.vel_y} + ay_q);
    age_sum    = {1'b0, rdata_q.age} + {7'd0, dt_q};
    age_new    = age_sum[31] ? 31'h7FFF_FFFF : age_sum[30:0];
    upd.age    = age_new;
    dead       = (age_new >= rdata_q.life);
  end

  logic [ppi_pkg::CntW-1:0] live_m1;
  assign live_m1 = live_q - 1'b1;

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k_q;
    wr_en   = 1'b0;
    wr_addr = k_q;
    wr_data = upd;
    case (state_q)
      S_IDLE: begin
        wr_en          = in_acc && (op_i == ppi_pkg::OpEmit)
                         && (live_q < ppi_pkg::CntW'(ppi_pkg::MaxParticles));
        wr_addr        = live_q[ppi_pkg::IdxW-1:0];
        wr_data.pos_x  = pos_x_i;
        wr_data.pos_y  = pos_y_i;
        wr_data.vel_x  = vel_x_i;
        wr_data.vel_y  = vel_y_i;
        wr_data.torque = torque_i;
        wr_data.angle  = '0;
        wr_data.age    = '0;
        wr_data.life   = life_i;
      end
      S_RD: rd_en = 1'b1;
      S_WB: begin
        wr_en   = 1'b1;
        rd_en   = dead;
        rd_addr = live_m1[ppi_pkg::IdxW-1:0];
      end
      S_MV: begin
        wr_en   = 1'b1;
        wr_data = rdata_q;
      end
      default: ;
    endcase
  end

  // Slot memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q <= dt_full[ppi_pkg::DtW+11:12];
    end
    if (state_q == S_ACC1 || state_q == S_MUL1) begin
      mt_q  <= p_t[57:16];
      mx1_q <= p_a[57:16];
      my1_q <= p_b[57:16];
    end
    if (state_q == S_ACC2) begin
      ax_q <= q_a[63:16];
      ay_q <= q_b[63:16];
    end
    if (state_q == S_MUL2) begin
      mx_q <= q_a[63:16];
      my_q <= q_b[63:16];
    end
  end

  // Control sequencer, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      speed_q     <= 16'd4096;
      dens_q      <= 21'd65536;
      accx_q      <= '0;
      accy_q      <= '0;
      live_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      status_o    <= '0;
      pos_x_res_o <= '0;
      pos_y_res_o <= '0;
      angle_o     <= '0;
      age_o       <= '0;
      life_res_o  <= '0;
      last_o      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ppi_pkg::RegSpeed:   speed_q <= cfg_wdata_i[15:0];
          ppi_pkg::RegDensity: dens_q  <= cfg_wdata_i[20:0];
          ppi_pkg::RegAccelX:  accx_q  <= cfg_wdata_i;
          ppi_pkg::RegAccelY:  accy_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op_i)
              ppi_pkg::OpEmit: begin
                last_o      <= 1'b1;
                angle_o     <= '0;
                age_o       <= '0;
                if (live_q < ppi_pkg::CntW'(ppi_pkg::MaxParticles)) begin
                  status_o    <= ppi_pkg::StEmitted;
                  pos_x_res_o <= pos_x_i;
                  pos_y_res_o <= pos_y_i;
                  life_res_o  <= life_i;
                  live_q      <= live_q + 1'b1;
                end else begin
                  status_o    <= ppi_pkg::StDropped;
                  pos_x_res_o <= '0;
                  pos_y_res_o <= '0;
                  life_res_o  <= '0;
                end
              end
              ppi_pkg::OpClear: begin
                last_o      <= 1'b1;
                status_o    <= ppi_pkg::StCleared;
                pos_x_res_o <= '0;
                pos_y_res_o <= '0;
                angle_o     <= '0;
                age_o       <= '0;
                life_res_o  <= '0;
                live_q      <= '0;
              end
              ppi_pkg::OpTick: state_q <= S_ACC1;
              default: ;
            endcase
          end
        end
        S_ACC1: state_q <= S_ACC2;
        S_ACC2: begin
          if (live_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= live_m1[ppi_pkg::IdxW-1:0];
            state_q <= S_RD;
          end
        end
        S_RD:  state_q <= S_LAT;
        S_LAT: state_q <= S_MUL1;
        S_MUL1: begin
          // Report the state before the update once the output is free.
          if (out_free) begin
            status_o    <= ppi_pkg::StReport;
            pos_x_res_o <= rdata_q.pos_x;
            pos_y_res_o <= rdata_q.pos_y;
            angle_o     <= rdata_q.angle;
            age_o       <= rdata_q.age;
            life_res_o  <= rdata_q.life;
            last_o      <= (k_q == '0);
            state_q     <= S_MUL2;
          end
        end
        S_MUL2: state_q <= S_WB;
        S_WB: begin
          if (dead) begin
            state_q <= S_MVLAT;
          end else if (k_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_RD;
          end
        end
        S_MVLAT: state_q <= S_MV;
        S_MV: begin
          live_q <= live_m1;
          if (k_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the particle pool integrator: random beats, predictor, scoreboard.
`timescale 1ns / 100ps

module tb;

  // One input beat.
  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        life;
    logic signed [31:0] torque;
    logic [20:0]        dt;
  } cmd_t;

  // One result beat.
  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] angle;
    logic [30:0]        age;
    logic [30:0]        life;
    logic               last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = ppi_pkg::RegSpeed;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = ppi_pkg::OpEmit;
  logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0, torque = '0;
  logic [30:0] life = '0;
  logic [20:0] delta_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [31:0] pos_x_res, pos_y_res, angle;
  logic [30:0] age, life_res;
  logic last;

  particle_pool_integrator uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .pos_x_i(pos_x), .pos_y_i(pos_y), .vel_x_i(vel_x), .vel_y_i(vel_y),
    .life_i(life), .torque_i(torque), .delta_time_i(delta_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .pos_x_res_o(pos_x_res), .pos_y_res_o(pos_y_res),
    .angle_o(angle), .age_o(age), .life_res_o(life_res), .last_o(last)
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cmd_t  pending_cmds[$];
  beat_t expected_beats[$];
  int errors = 0;
  int beats_seen = 0;
  int n_emit = 0, n_tick = 0, n_clear = 0, n_drop = 0, n_reports = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;

  // Shadow copy of the registers and the particle pool.
  logic [15:0] m_speed = 16'd4096;
  logic [20:0] m_density = 21'd65536;
  logic signed [31:0] m_accel_x = '0, m_accel_y = '0;
  int unsigned m_count = 0;
  logic signed [31:0] p_px[ppi_pkg::MaxParticles], p_py[ppi_pkg::MaxParticles];
  logic signed [31:0] p_vx[ppi_pkg::MaxParticles], p_vy[ppi_pkg::MaxParticles];
  logic signed [31:0] p_ang[ppi_pkg::MaxParticles], p_trq[ppi_pkg::MaxParticles];
  logic [30:0] p_age[ppi_pkg::MaxParticles], p_life[ppi_pkg::MaxParticles];

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic beat_t mk(logic [1:0] st, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] a, logic [30:0] ag, logic [30:0] lf,
                               logic lst);
    beat_t b;
    b.status = st; b.px = x; b.py = y; b.angle = a; b.age = ag; b.life = lf; b.last = lst;
    return b;
  endfunction

  // Work out the result beats of one accepted command and advance the pool.
  task automatic integrate_cmd(cmd_t c);
    longint spd, step, dens, ax, ay, mx, my, nage;
    int unsigned s, l;
    if (c.op == ppi_pkg::OpEmit) begin
      if (m_count >= ppi_pkg::MaxParticles) begin
        expected_beats.push_back(mk(ppi_pkg::StDropped, 0, 0, 0, 0, 0, 1'b1));
        n_drop++;
      end else begin
        s = m_count;
        p_px[s] = c.px; p_py[s] = c.py; p_vx[s] = c.vx; p_vy[s] = c.vy;
        p_trq[s] = c.torque; p_ang[s] = 0; p_age[s] = 0; p_life[s] = c.life;
        m_count++;
        expected_beats.push_back(mk(ppi_pkg::StEmitted, c.px, c.py, 0, 0, c.life, 1'b1));
      end
      n_emit++;
    end else if (c.op == ppi_pkg::OpClear) begin
      m_count = 0;
      expected_beats.push_back(mk(ppi_pkg::StCleared, 0, 0, 0, 0, 0, 1'b1));
      n_clear++;
    end else if (c.op == ppi_pkg::OpTick) begin
      spd = (m_speed > ppi_pkg::SpeedMax) ? longint'(ppi_pkg::SpeedMax) : longint'(m_speed);
      step = (longint'(c.dt) * spd) >>> 12;
      dens = longint'(m_density);
      ax = (((longint'(m_accel_x) * step) >>> 16) * dens) >>> 16;
      ay = (((longint'(m_accel_y) * step) >>> 16) * dens) >>> 16;
      for (int k = int'(m_count) - 1; k >= 0; k--) begin
        expected_beats.push_back(mk(ppi_pkg::StReport, p_px[k], p_py[k], p_ang[k],
                                    p_age[k], p_life[k], k == 0));
        n_reports++;
        p_ang[k] = clip32(longint'(p_ang[k]) + ((longint'(p_trq[k]) * step) >>> 16));
        mx = (((longint'(p_vx[k]) * step) >>> 16) * dens) >>> 16;
        my = (((longint'(p_vy[k]) * step) >>> 16) * dens) >>> 16;
        p_px[k] = clip32(longint'(p_px[k]) + mx);
        p_py[k] = clip32(longint'(p_py[k]) + my);
        p_vx[k] = clip32(longint'(p_vx[k]) + ax);
        p_vy[k] = clip32(longint'(p_vy[k]) + ay);
        nage = longint'(p_age[k]) + step;
        if (nage > 64'sd2147483647) nage = 64'sd2147483647;
        p_age[k] = nage[30:0];
        if (p_age[k] >= p_life[k]) begin
          l = m_count - 1;
          p_px[k] = p_px[l]; p_py[k] = p_py[l]; p_vx[k] = p_vx[l]; p_vy[k] = p_vy[l];
          p_ang[k] = p_ang[l]; p_trq[k] = p_trq[l];
          p_age[k] = p_age[l]; p_life[k] = p_life[l];
          m_count = l;
        end
      end
      n_tick++;
    end
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Driver: offers the queued commands with random gaps.
  int send_gap = 0;
  always @(posedge clk_i) begin
    cmd_t c;
    logic nv;
    nv = in_valid;
    if (in_valid && !in_stall) begin
      integrate_cmd('{op, pos_x, pos_y, vel_x, vel_y, life, torque, delta_time});
      nv = 1'b0;
      if (!calm) begin
        case ($urandom_range(0, 19))
          0:       send_gap = $urandom_range(10, 40);
          1, 2, 3, 4, 5: send_gap = $urandom_range(1, 3);
          default: send_gap = 0;
        endcase
      end
    end
    if (!nv && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        op <= c.op; pos_x <= c.px; pos_y <= c.py; vel_x <= c.vx; vel_y <= c.vy;
        life <= c.life; torque <= c.torque; delta_time <= c.dt;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
  end

  // Receiver stall pattern, with one long hold-off once 120 result beats have been seen.
  int stall_left = 0;
  always @(posedge clk_i) begin
    logic ns;
    ns = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if (!hold_done && beats_seen >= 120) begin
      hold_done = 1'b1;
      stall_left = 400;
      ns = 1'b1;
    end else if (!calm) begin
      case ($urandom_range(0, 19))
        0:       begin stall_left = $urandom_range(10, 40); ns = 1'b1; end
        1, 2, 3, 4: begin stall_left = $urandom_range(0, 2); ns = 1'b1; end
        default: ns = 1'b0;
      endcase
    end
    out_stall <= ns;
  end

  // Monitor: compares every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid && !out_stall) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, status %0d", status));
      end else begin
        e = expected_beats.pop_front();
        if (status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", status, e.status));
        if (pos_x_res !== e.px)
          report_mismatch($sformatf("pos_x %0h, want %0h", pos_x_res, e.px));
        if (pos_y_res !== e.py)
          report_mismatch($sformatf("pos_y %0h, want %0h", pos_y_res, e.py));
        if (angle !== e.angle)
          report_mismatch($sformatf("angle %0h, want %0h", angle, e.angle));
        if (age !== e.age)
          report_mismatch($sformatf("age %0h, want %0h", age, e.age));
        if (life_res !== e.life)
          report_mismatch($sformatf("life %0h, want %0h", life_res, e.life));
        if (last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", last, e.last));
      end
    end
  end

  // Register write; the shadow registers are updated when the write is driven, before the block takes it.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      ppi_pkg::RegSpeed:   m_speed = val[15:0];
      ppi_pkg::RegDensity: m_density = val[20:0];
      ppi_pkg::RegAccelX:  m_accel_x = val;
      default:             m_accel_y = val;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every command is taken and every result has arrived.
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic cmd_t rnd_cmd(int emit_pct);
    cmd_t c;
    int r;
    c.px = rnd_word(); c.py = rnd_word(); c.vx = rnd_word(); c.vy = rnd_word();
    c.torque = rnd_word();
    c.life = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                         : 31'($urandom_range(0, 32'h0008_0000));
    c.dt = ($urandom_range(0, 9) == 0) ? 21'd1048576
                                       : 21'($urandom_range(0, 32'h0002_0000));
    r = $urandom_range(0, 99);
    if (r < emit_pct) c.op = ppi_pkg::OpEmit;
    else if (r < 95) c.op = ppi_pkg::OpTick;
    else if (r < 98) c.op = ppi_pkg::OpClear;
    else c.op = 2'd3;
    return c;
  endfunction

  function automatic cmd_t dcmd(logic [1:0] o, logic signed [31:0] x, logic signed [31:0] v,
                                logic [30:0] lf, logic [20:0] d);
    cmd_t c;
    c.op = o; c.px = x; c.py = ~x; c.vx = v; c.vy = -v; c.torque = v;
    c.life = lf; c.dt = d;
    return c;
  endfunction

  task automatic random_phase(int count, int emit_pct, bit quiet);
    calm = quiet;
    repeat (count) pending_cmds.push_back(rnd_cmd(emit_pct));
    drain();
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty tick, field extremes, zero and full life, clear, unused opcode.
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd4096));
    pending_cmds.push_back(dcmd(ppi_pkg::OpEmit, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                31'h7FFF_FFFF, 0));
    pending_cmds.push_back(dcmd(ppi_pkg::OpEmit, 32'sh8000_0000, 32'sh8000_0000,
                                31'h7FFF_FFFF, 0));
    pending_cmds.push_back(dcmd(ppi_pkg::OpEmit, 32'sh0001_0000, 32'sh0000_8000, 31'd0, 0));
    pending_cmds.push_back(dcmd(ppi_pkg::OpEmit, -32'sh0005_0000, 32'sh0002_0000,
                                31'd65536, 0));
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd0));
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd1048576));
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd1048576));
    pending_cmds.push_back(dcmd(2'd3, 32'sh1234_5678, 32'sh1, 31'd5, 21'd7));
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd32768));
    pending_cmds.push_back(dcmd(ppi_pkg::OpClear, 0, 0, 0, 0));
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd65536));
    pending_cmds.push_back(dcmd(ppi_pkg::OpEmit, 32'shFFFF_FFFF, 32'sh7FFF_0000, 31'd1,
                                21'h1F_FFFF));
    pending_cmds.push_back(dcmd(ppi_pkg::OpTick, 0, 0, 0, 21'd1));
    drain();

    random_phase(70, 55, 1'b0);

    // Stopped time at speed zero: nothing dies, so the pool fills and drops.
    write_reg(ppi_pkg::RegSpeed, 32'd0);
    write_reg(ppi_pkg::RegDensity, 32'd1048576);
    write_reg(ppi_pkg::RegAccelX, 32'h7FFF_FFFF);
    write_reg(ppi_pkg::RegAccelY, 32'h8000_0000);
    end_writes();
    random_phase(90, 85, 1'b0);

    // Speed above the clamp at zero density, so only angle and age advance.
    write_reg(ppi_pkg::RegSpeed, 32'd65535);
    write_reg(ppi_pkg::RegDensity, 32'd0);
    end_writes();
    random_phase(60, 60, 1'b1);

    write_reg(ppi_pkg::RegSpeed, 32'd40960);
    write_reg(ppi_pkg::RegDensity, 32'd1048576);
    write_reg(ppi_pkg::RegAccelX, 32'h8000_0000);
    write_reg(ppi_pkg::RegAccelY, 32'h7FFF_FFFF);
    end_writes();
    random_phase(60, 60, 1'b0);

    write_reg(ppi_pkg::RegSpeed, 32'($urandom_range(0, 40960)));
    write_reg(ppi_pkg::RegDensity, 32'($urandom_range(0, 1048576)));
    write_reg(ppi_pkg::RegAccelX, rnd_word());
    write_reg(ppi_pkg::RegAccelY, rnd_word());
    end_writes();
    random_phase(60, 65, 1'b0);

    write_reg(ppi_pkg::RegSpeed, 32'd4096);
    write_reg(ppi_pkg::RegDensity, 32'd65536);
    write_reg(ppi_pkg::RegAccelX, 32'd0);
    write_reg(ppi_pkg::RegAccelY, 32'd0);
    end_writes();
    random_phase(80, 60, 1'b0);

    repeat (50) @(posedge clk_i);
    $display("Covered %0d emits (%0d dropped), %0d ticks, %0d clears.",
             n_emit, n_drop, n_tick, n_clear);
    $display("Checked %0d result beats, %0d of them particle reports.", beats_seen, n_reports);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("particle_pool_integrator verification clean");
    end else begin
      $display("particle_pool_integrator verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("Timed out with %0d beats still expected.", expected_beats.size());
    $display("particle_pool_integrator verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ppi_pkg.sv
hw/rtl/particle_pool_integrator.sv
sim/tb.sv
